[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, skipped while reset is asserted.
`define AOB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define AOB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[rtl/aob_pkg.sv]
// Types and constants of the alpha-over blend block.
package aob_pkg;

  localparam logic [7:0] MaxV     = 8'd255;
  localparam int         NumLanes = 3;
  localparam int         DivSteps = 8;
  localparam int         DenW     = 16;
  localparam int         RemW     = 24;
  localparam int         OpacityW = 9;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } aob_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } aob_out_t;

  typedef enum logic [1:0] {
    CLS_BLEND    = 2'd0,
    CLS_PASS_DST = 2'd1,
    CLS_PASS_SRC = 2'd2
  } aob_cls_e;

  // Classified request between front and back.
  typedef struct packed {
    aob_cls_e   cls;
    logic [7:0] sa;
    aob_in_t    pix;
  } aob_mid_t;

  // One stage of the divider pipeline, three color lanes.
  typedef struct packed {
    aob_cls_e                          cls;
    aob_out_t                          pass;
    logic [DenW-1:0]                   den;
    logic [NumLanes-1:0][RemW-1:0]     rem;
    logic [NumLanes-1:0][DivSteps-1:0] quot;
  } aob_div_t;

endpackage

[rtl/aob_fifo.sv]
// Small register queue with push/full and pop/empty sides.
module aob_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/aob_front.sv]
// Front end: opacity register, effective alpha and request classification.
module aob_front import aob_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [OpacityW-1:0] cfg_wdata_i,
  input  aob_in_t             item_i,
  output aob_mid_t            mid_o
);

  logic [OpacityW-1:0] opacity_q;
  logic [16:0]         alpha_prod;
  logic [8:0]          sa_wide;
  logic [7:0]          sa;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= OpacityW'(256);
    end else if (cfg_we_i) begin
      opacity_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    alpha_prod = 17'(item_i.src_alpha) * 17'(opacity_q);
    sa_wide    = alpha_prod[16:8];
    // opacity above 256 can push sa past full scale
    sa         = (sa_wide > 9'(MaxV)) ? MaxV : sa_wide[7:0];
    mid_o.sa   = sa;
    mid_o.pix  = item_i;
    if (sa == 8'd0) begin
      mid_o.cls = CLS_PASS_DST;
    end else if (sa == MaxV) begin
      mid_o.cls = CLS_PASS_SRC;
    end else begin
      mid_o.cls = CLS_BLEND;
    end
  end

endmodule

[rtl/aob_back.sv]
// Back end: weight computation, products and pipelined restoring divider.
module aob_back import aob_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  aob_mid_t mid_i,
  input  logic     mid_empty_i,
  output logic     mid_pop_o,
  output aob_out_t res_o,
  output logic     res_push_o,
  input  logic     res_full_i
);

  typedef struct packed {
    aob_cls_e   cls;
    logic [7:0] sa;
    aob_in_t    pix;
    logic [15:0] p;
  } aob_s1_t;

  typedef struct packed {
    aob_cls_e        cls;
    logic [7:0]      sa;
    logic [7:0]      da;
    logic [DenW-1:0] den;
    aob_in_t         pix;
  } aob_s2_t;

  typedef struct packed {
    aob_cls_e                      cls;
    logic [DenW-1:0]               den;
    aob_in_t                       pix;
    logic [NumLanes-1:0][15:0]     prod_s;
    logic [NumLanes-1:0][15:0]     prod_d;
  } aob_s3_t;

  aob_s1_t  s1_q, s1_d;
  aob_s2_t  s2_q, s2_d;
  aob_s3_t  s3_q, s3_d;
  aob_div_t div_q [DivSteps+1];
  aob_div_t div_d [DivSteps+1];
  logic     v1_q, v2_q, v3_q;
  logic [DivSteps:0] dv_q;
  logic     adv;

  // whole pipeline moves unless the last stage is blocked by the result queue
  assign adv        = !dv_q[DivSteps] || !res_full_i;
  assign mid_pop_o  = adv && !mid_empty_i;
  assign res_push_o = dv_q[DivSteps] && adv;

  // stage 1: (255 - sa) * dst_alpha
  always_comb begin
    logic [7:0] inv_sa;
    inv_sa   = MaxV - mid_i.sa;
    s1_d.cls = mid_i.cls;
    s1_d.sa  = mid_i.sa;
    s1_d.pix = mid_i.pix;
    s1_d.p   = 16'(inv_sa) * 16'(mid_i.pix.dst_alpha);
  end

  // stage 2: da = p / 255, den = 255*sa + p
  always_comb begin
    logic [16:0] div_acc;
    div_acc  = 17'(s1_q.p) + 17'(s1_q.p[15:8]) + 17'd1;
    s2_d.cls = s1_q.cls;
    s2_d.sa  = s1_q.sa;
    s2_d.pix = s1_q.pix;
    s2_d.da  = div_acc[15:8];
    s2_d.den = DenW'((17'(s2_d.sa) << 8) - 17'(s1_q.sa) + 17'(s1_q.p));
  end

  // stage 3: per-lane products
  always_comb begin
    logic [NumLanes-1:0][7:0] s_ch;
    logic [NumLanes-1:0][7:0] d_ch;
    s_ch     = {s2_q.pix.src_red, s2_q.pix.src_green, s2_q.pix.src_blue};
    d_ch     = {s2_q.pix.dst_red, s2_q.pix.dst_green, s2_q.pix.dst_blue};
    s3_d.cls = s2_q.cls;
    s3_d.den = s2_q.den;
    s3_d.pix = s2_q.pix;
    for (int l = 0; l < NumLanes; l++) begin
      s3_d.prod_s[l] = 16'(s_ch[l]) * 16'(s2_q.sa);
      s3_d.prod_d[l] = 16'(d_ch[l]) * 16'(s2_q.da);
    end
  end

  // stage 4: numerator 255 * sum, pick the pass pixel
  always_comb begin
    logic [16:0] sum;
    logic [24:0] num;
    div_d[0].cls  = s3_q.cls;
    div_d[0].den  = s3_q.den;
    div_d[0].quot = '0;
    div_d[0].rem  = '0;
    for (int l = 0; l < NumLanes; l++) begin
      sum = 17'(s3_q.prod_s[l]) + 17'(s3_q.prod_d[l]);
      num = (25'(sum) << 8) - 25'(sum);
      div_d[0].rem[l] = num[RemW-1:0];
    end
    case (s3_q.cls)
      CLS_PASS_SRC: div_d[0].pass = {s3_q.pix.src_red, s3_q.pix.src_green,
                                     s3_q.pix.src_blue, s3_q.pix.src_alpha};
      default:      div_d[0].pass = {s3_q.pix.dst_red, s3_q.pix.dst_green,
                                     s3_q.pix.dst_blue, s3_q.pix.dst_alpha};
    endcase
  end

  // one quotient bit per stage; the quotient is known to fit in 8 bits
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int Sh = DivSteps - 1 - k;
    always_comb begin
      logic [RemW-1:0] trial;
      div_d[k+1] = div_q[k];
      trial      = RemW'(div_q[k].den) << Sh;
      for (int l = 0; l < NumLanes; l++) begin
        if (div_q[k].rem[l] >= trial) begin
          div_d[k+1].rem[l]  = div_q[k].rem[l] - trial;
          div_d[k+1].quot[l] = {div_q[k].quot[l][DivSteps-2:0], 1'b1};
        end else begin
          div_d[k+1].quot[l] = {div_q[k].quot[l][DivSteps-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    unique case (div_q[DivSteps].cls)
      CLS_BLEND: begin
        res_o.out_red   = div_q[DivSteps].quot[2];
        res_o.out_green = div_q[DivSteps].quot[1];
        res_o.out_blue  = div_q[DivSteps].quot[0];
        res_o.out_alpha = MaxV;
      end
      default: res_o = div_q[DivSteps].pass;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      dv_q <= '0;
    end else if (adv) begin
      v1_q <= !mid_empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      dv_q <= {dv_q[DivSteps-1:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      for (int k = 0; k <= DivSteps; k++) begin
        div_q[k] <= div_d[k];
      end
    end
  end

endmodule

[rtl/alpha_over_blend_with_opacity.sv]
// Top level of the alpha-over blend block with global opacity.
// Usage:
//  - Input queue side: drive item_i and raise push_i; the request is taken
//    on a clock edge with push_i high and full_o low.
//  - Result queue side: while empty_o is low, result_o holds the oldest
//    result; raise pop_i to take it.
//  - cfg_we_i writes cfg_wdata_i to the opacity register (256 = opaque);
//    write only while no request is in flight.
// Timing:
//  - One request per clock sustained while nothing stalls; the front
//    classifies in the accept cycle, the back runs a 12-stage pipeline
//    (weights, products, and an 8-step restoring divider, one quotient
//    bit per stage).
// Reset: queues and pipeline empty, opacity = 256.
// Stall: when pop_i stays low the result queue fills, the back pipeline
//  freezes, the middle queue fills and full_o rises. Nothing is dropped.
module alpha_over_blend_with_opacity import aob_pkg::*; #(
  parameter int MidDepth = 4,
  parameter int OutDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  aob_in_t             item_i,
  output logic                empty_o,
  input  logic                pop_i,
  output aob_out_t            result_o,
  input  logic                cfg_we_i,
  input  logic [OpacityW-1:0] cfg_wdata_i
);

  localparam int MidW = $bits(aob_mid_t);
  localparam int OutW = $bits(aob_out_t);

  aob_mid_t        mid_in;
  logic [MidW-1:0] mid_raw;
  logic            mid_empty, mid_pop;
  aob_out_t        res;
  logic            res_push, res_full;
  logic [OutW-1:0] out_raw;

  // classify at accept
  aob_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .mid_o       (mid_in)
  );

  // decouples front from back
  aob_fifo #(
    .Width (MidW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (mid_in),
    .full_o  (full_o),
    .pop_i   (mid_pop),
    .data_o  (mid_raw),
    .empty_o (mid_empty)
  );

  aob_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_i       (aob_mid_t'(mid_raw)),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue; the back stalls only when this queue is full and its last stage holds a result
  aob_fifo #(
    .Width (OutW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (out_raw),
    .empty_o (empty_o)
  );

  assign result_o = aob_out_t'(out_raw);

endmodule

[rtl/aob_checker.sv]
// Port-level checker for the alpha-over blend block, with its bind.
`include "assert_macros.svh"

module aob_checker import aob_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push_i,
  input logic     full_o,
  input logic     empty_o,
  input logic     pop_i,
  input aob_out_t result_o
);

  logic [7:0] pend_q;
  logic       acc_in, acc_out;

  assign acc_in  = push_i && !full_o;
  assign acc_out = pop_i && !empty_o;

  // requests accepted and not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (acc_in && !acc_out) begin
      pend_q <= pend_q + 1'b1;
    end else if (acc_out && !acc_in) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // a reset seen at a clock edge implies an empty result queue in the next cycle
  `AOB_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |=> empty_o)
  `AOB_ASSERT(a_no_phantom_result, clk_i, rst_ni, !empty_o |-> pend_q != 8'd0)
  `AOB_ASSERT(a_idle_not_full, clk_i, rst_ni, pend_q == 8'd0 |-> !full_o)
  `AOB_ASSERT(a_result_holds, clk_i, rst_ni,
    (!empty_o && !pop_i) |=> (!empty_o && $stable(result_o)))

endmodule

bind alpha_over_blend_with_opacity aob_checker u_aob_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push_i   (push_i),
  .full_o   (full_o),
  .empty_o  (empty_o),
  .pop_i    (pop_i),
  .result_o (result_o)
);

[bench/testbench.sv]
// Self-checking testbench for the alpha-over blend block with global opacity.
`timescale 1ns / 1ps

module testbench;
  import aob_pkg::*;

  // Generous bound on the slowest run: about 1700 requests with random
  // idle gaps on both sides, plus drains and opacity writes.
  localparam int unsigned RunLimitNs   = 400000;
  // Idle wait at the end, longer than the no-stall latency of the block.
  localparam int          SettleCycles = 24;
  localparam int          ChunkItems   = 110;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                push      = 1'b0;
  logic                full;
  aob_in_t             item      = '0;
  logic                empty;
  logic                pop       = 1'b0;
  aob_out_t            result;
  logic                cfg_we    = 1'b0;
  logic [OpacityW-1:0] cfg_wdata = '0;

  // Predictor copy of the opacity register; matches the reset value.
  logic [OpacityW-1:0] opacity_model = 9'd256;

  // Expected results still to come out, oldest first.
  aob_out_t expected_pixels[$];

  // Idle rates, in percent, for the sender and for the receiver.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  int errors         = 0;
  int checked        = 0;
  int blend_count    = 0;
  int pass_dst_count = 0;
  int pass_src_count = 0;
  int opacity_writes = 0;

  alpha_over_blend_with_opacity u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push_i     (push),
    .full_o     (full),
    .item_i     (item),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // 2 ns clock: high for 1 ns, low for 1 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Over operator with opacity. The class tells which path the pixel took.
  function automatic aob_out_t blend_over(input aob_in_t px, input logic [OpacityW-1:0] opac,
                                          output aob_cls_e cls);
    int unsigned eff_alpha;
    int unsigned dst_weight;
    int unsigned den;
    int unsigned src_ch[3];
    int unsigned dst_ch[3];
    int unsigned q;
    aob_out_t    px_out;
    begin
      eff_alpha = (int'(px.src_alpha) * int'(opac)) >> 8;
      // Opacity above 256 can push the effective alpha past 255: clamp it.
      if (eff_alpha > 255) eff_alpha = 255;
      if (eff_alpha == 0) begin
        // Source invisible: destination passes as is, alpha included.
        cls    = CLS_PASS_DST;
        px_out = '{px.dst_red, px.dst_green, px.dst_blue, px.dst_alpha};
      end else if (eff_alpha == 255) begin
        // Source fully opaque: source passes as is, alpha included.
        cls    = CLS_PASS_SRC;
        px_out = '{px.src_red, px.src_green, px.src_blue, px.src_alpha};
      end else begin
        cls        = CLS_BLEND;
        dst_weight = (int'(px.dst_alpha) * (255 - eff_alpha)) / 255;
        // eff_alpha >= 1 here, so the divisor is never zero.
        den        = 255 * eff_alpha + (255 - eff_alpha) * int'(px.dst_alpha);
        src_ch     = '{px.src_red, px.src_green, px.src_blue};
        dst_ch     = '{px.dst_red, px.dst_green, px.dst_blue};
        for (int i = 0; i < 3; i++) begin
          q = (255 * (src_ch[i] * eff_alpha + dst_ch[i] * dst_weight)) / den;
          if (q > 255) q = 255;
          src_ch[i] = q;
        end
        px_out = '{src_ch[0][7:0], src_ch[1][7:0], src_ch[2][7:0], MaxV};
      end
      return px_out;
    end
  endfunction

  // Sends one request; enters and leaves just after a falling edge. push
  // stays high on return so back-to-back requests need no extra edge.
  task automatic send_pixel(input aob_in_t px);
    aob_out_t px_exp;
    aob_cls_e cls;
    begin
      while ($urandom_range(99) < send_gap_pct) begin
        push <= 1'b0;
        @(negedge clk);
      end
      push <= 1'b1;
      item <= px;
      do @(posedge clk); while (full);
      // Accepted on this edge: predict with the current opacity.
      px_exp = blend_over(px, opacity_model, cls);
      expected_pixels = {expected_pixels, px_exp};
      case (cls)
        CLS_BLEND:    blend_count++;
        CLS_PASS_DST: pass_dst_count++;
        default:      pass_src_count++;
      endcase
      @(negedge clk);
    end
  endtask

  // Holds off requests until every outstanding result has been popped.
  task automatic drain_results();
    begin
      push <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clk);
    end
  endtask

  // Opacity writes happen only with the block drained.
  task automatic set_opacity(input logic [OpacityW-1:0] opac);
    begin
      drain_results();
      cfg_we    <= 1'b1;
      cfg_wdata <= opac;
      @(negedge clk);
      cfg_we        <= 1'b0;
      opacity_model  = opac;
      opacity_writes++;
    end
  endtask

  function automatic aob_in_t random_pixel();
    aob_in_t px;
    begin
      px = {$urandom, $urandom};
      // Bias the alphas toward their end points now and then.
      case ($urandom_range(7))
        0: px.src_alpha = 8'h00;
        1: px.src_alpha = 8'hFF;
        default: ;
      endcase
      case ($urandom_range(7))
        0: px.dst_alpha = 8'h00;
        1: px.dst_alpha = 8'hFF;
        default: ;
      endcase
      return px;
    end
  endfunction

  // Receiver: decide pop at the falling edge, check at the rising edge.
  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_channel(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    begin
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    aob_out_t px_exp;
    if (rst_n && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no request outstanding: %h", result);
        errors++;
      end else begin
        px_exp = expected_pixels.pop_front();
        check_channel("out_red",   px_exp.out_red,   result.out_red);
        check_channel("out_green", px_exp.out_green, result.out_green);
        check_channel("out_blue",  px_exp.out_blue,  result.out_blue);
        check_channel("out_alpha", px_exp.out_alpha, result.out_alpha);
        checked++;
      end
    end
  end

  // Reset value of opacity is 256: cover both pass paths and a blend.
  task automatic test_default_opacity();
    begin
      send_pixel('{8'd10, 8'd20, 8'd30, 8'hFF, 8'd40, 8'd50, 8'd60, 8'd70});
      send_pixel('{8'd11, 8'd22, 8'd33, 8'h00, 8'd44, 8'd55, 8'd66, 8'd77});
      send_pixel('{8'd200, 8'd100, 8'd50, 8'd128, 8'd25, 8'd75, 8'd225, 8'd128});
      drain_results();
    end
  endtask

  // Channel extremes and the smallest and largest blending alphas.
  task automatic test_pixel_extremes();
    begin
      send_pixel('0);
      send_pixel('1);
      send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00});
      send_pixel('{8'h00, 8'h00, 8'h00, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_pixel('{8'hFF, 8'h00, 8'hFF, 8'd254, 8'h00, 8'hFF, 8'h00, 8'hFF});
      send_pixel('{8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA});
      send_pixel('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55});
      drain_results();
    end
  endtask

  // Zero and tiny opacity: effective alpha rounds to zero.
  task automatic test_opacity_zero();
    begin
      set_opacity(9'd0);
      send_pixel('{8'd1, 8'd2, 8'd3, 8'hFF, 8'd4, 8'd5, 8'd6, 8'd7});
      send_pixel('1);
      set_opacity(9'd1);
      send_pixel('{8'd9, 8'd8, 8'd7, 8'hFF, 8'd6, 8'd5, 8'd4, 8'd3});
      drain_results();
    end
  endtask

  // Opacity above 256: effective alpha saturates at 255.
  task automatic test_opacity_saturation();
    begin
      set_opacity(9'd511);
      send_pixel('{8'd90, 8'd80, 8'd70, 8'hFF, 8'd1, 8'd2, 8'd3, 8'd4});
      send_pixel('{8'd90, 8'd80, 8'd70, 8'd128, 8'd1, 8'd2, 8'd3, 8'd4});
      send_pixel('{8'd90, 8'd80, 8'd70, 8'd1, 8'd1, 8'd2, 8'd3, 8'd200});
      send_pixel('{8'd90, 8'd80, 8'd70, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4});
      set_opacity(9'd257);
      send_pixel('{8'd12, 8'd34, 8'd56, 8'hFF, 8'd78, 8'd90, 8'd12, 8'd34});
      send_pixel('{8'd12, 8'd34, 8'd56, 8'd254, 8'd78, 8'd90, 8'd12, 8'd34});
      drain_results();
    end
  endtask

  // Random pixels in chunks; opacity changes between chunks, which also
  // forces a full drain of the block each time.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int num_items);
    logic [OpacityW-1:0] corner_opac[11];
    int                  sent;
    begin
      corner_opac    = '{9'd0, 9'd1, 9'd2, 9'd127, 9'd128, 9'd255, 9'd256,
                         9'd257, 9'd384, 9'd510, 9'd511};
      send_gap_pct   = send_pct;
      recv_stall_pct = recv_pct;
      sent           = 0;
      while (sent < num_items) begin
        if ($urandom_range(1)) set_opacity(corner_opac[$urandom_range(10)]);
        else set_opacity(9'($urandom_range(511)));
        for (int i = 0; i < ChunkItems && sent < num_items; i++) begin
          send_pixel(random_pixel());
          sent++;
        end
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_gap_pct   = 23;
    recv_stall_pct = 65;
    test_default_opacity();
    test_pixel_extremes();
    test_opacity_zero();
    test_opacity_saturation();

    // Slow receiver, then slow sender, then full rate both ways.
    test_random_traffic(23, 65, 550);
    test_random_traffic(65, 23, 550);
    test_random_traffic(0, 0, 550);

    // Nothing outstanding; give a stray late result time to show up.
    repeat (SettleCycles) @(negedge clk);

    $display("Covered %0d requests: %0d blended, %0d destination and %0d source passes.",
             blend_count + pass_dst_count + pass_src_count, blend_count,
             pass_dst_count, pass_src_count);
    $display("%0d opacity writes, %0d results checked, three idle patterns.",
             opacity_writes, checked);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RunLimitNs);
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/aob_pkg.sv
rtl/aob_fifo.sv
rtl/aob_front.sv
rtl/aob_back.sv
rtl/alpha_over_blend_with_opacity.sv
rtl/aob_checker.sv
bench/testbench.sv
